// ===== sv/cse_pkg.sv =====
// shared types and constants of the chaocipher symbol engine
package cse_pkg;

    localparam int SYM_W  = 5;
    localparam int KIND_W = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD_LEFT  = 2'd0,
        KIND_LOAD_RIGHT = 2'd1,
        KIND_ENCRYPT    = 2'd2,
        KIND_DECRYPT    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_TWIST
    } t_state;

    typedef struct packed {
        logic load_left;
        logic load_right;
        logic copy;
        logic rotate;
        logic twist;
    } t_cell_ctl;

endpackage

// ===== sv/cse_cell.sv =====
// one alphabet slot: left and right key entries and working entries
module cse_cell (
    input  logic                     i_clk,
    input  cse_pkg::t_cell_ctl       i_ctl,
    input  logic                     i_load_left,
    input  logic                     i_load_right,
    input  logic [cse_pkg::SYM_W-1:0] i_key_data,
    input  logic [cse_pkg::SYM_W-1:0] i_left_next,
    input  logic [cse_pkg::SYM_W-1:0] i_right_next,
    input  logic [cse_pkg::SYM_W-1:0] i_left_twist,
    input  logic [cse_pkg::SYM_W-1:0] i_right_twist,
    output logic [cse_pkg::SYM_W-1:0] o_left,
    output logic [cse_pkg::SYM_W-1:0] o_right
);

    logic [cse_pkg::SYM_W-1:0] r_left_key;
    logic [cse_pkg::SYM_W-1:0] r_right_key;
    logic [cse_pkg::SYM_W-1:0] r_left_work;
    logic [cse_pkg::SYM_W-1:0] r_right_work;

    always_ff @(posedge i_clk) begin
        if (i_load_left) begin
            r_left_key <= i_key_data;
        end
        if (i_load_right) begin
            r_right_key <= i_key_data;
        end
    end

    // working entries: reload, step one slot toward the zenith, or twist
    always_ff @(posedge i_clk) begin
        if (i_ctl.copy) begin
            r_left_work  <= r_left_key;
            r_right_work <= r_right_key;
        end else if (i_ctl.rotate) begin
            r_left_work  <= i_left_next;
            r_right_work <= i_right_next;
        end else if (i_ctl.twist) begin
            r_left_work  <= i_left_twist;
            r_right_work <= i_right_twist;
        end
    end

    assign o_left  = r_left_work;
    assign o_right = r_right_work;

endmodule

// ===== sv/cse_ctrl.sv =====
// sequencer: accept, search by rotation, twist, result register
module cse_ctrl #(
    parameter int SYMBOLS = 27
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic [cse_pkg::KIND_W-1:0] i_kind,
    input  logic [cse_pkg::SYM_W-1:0]  i_symbol,
    input  logic                      i_restart,
    input  logic                      i_pos_ok,
    input  logic                      i_sym_ok,
    input  logic [cse_pkg::SYM_W-1:0]  i_left0,
    input  logic [cse_pkg::SYM_W-1:0]  i_right0,
    input  logic                      i_out_stall,
    output logic                      o_in_stall,
    output cse_pkg::t_cell_ctl        o_ctl,
    output logic                      o_take,
    output logic [cse_pkg::SYM_W-1:0]  o_result,
    output logic                      o_out_valid
);

    localparam int CNT_W = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SYMBOLS - 1);

    cse_pkg::t_state           r_state, n_state;
    logic [CNT_W-1:0]          r_count, n_count;
    logic [cse_pkg::SYM_W-1:0] r_sym, n_sym;
    logic                      r_dec, n_dec;
    logic                      r_out_valid, n_out_valid;

    logic w_accept;
    logic w_run;
    logic w_match;
    logic w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cse_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym <= n_sym;
        r_dec <= n_dec;
    end

    assign w_accept   = i_in_valid && (r_state == cse_pkg::ST_IDLE);
    assign w_run      = (i_kind == cse_pkg::KIND_ENCRYPT) || (i_kind == cse_pkg::KIND_DECRYPT);
    assign w_match    = (r_dec ? i_left0 : i_right0) == r_sym;
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state        = r_state;
        n_count        = r_count;
        n_sym          = r_sym;
        n_dec          = r_dec;
        o_ctl          = '0;
        o_take         = 1'b0;
        o_ctl.load_left  = w_accept && (i_kind == cse_pkg::KIND_LOAD_LEFT)
                           && i_pos_ok && i_sym_ok;
        o_ctl.load_right = w_accept && (i_kind == cse_pkg::KIND_LOAD_RIGHT)
                           && i_pos_ok && i_sym_ok;
        case (r_state)
            cse_pkg::ST_IDLE: begin
                o_ctl.copy = w_accept && w_run && i_restart;
                if (w_accept && w_run && i_sym_ok) begin
                    n_state = cse_pkg::ST_SEARCH;
                    n_count = '0;
                    n_sym   = i_symbol;
                    n_dec   = (i_kind == cse_pkg::KIND_DECRYPT);
                end
            end
            cse_pkg::ST_SEARCH: begin
                if (w_match) begin
                    // hold the match until the result register frees
                    if (w_out_free) begin
                        o_take  = 1'b1;
                        n_state = cse_pkg::ST_TWIST;
                    end
                end else begin
                    o_ctl.rotate = 1'b1;
                    if (r_count == CNT_LAST) begin
                        n_state = cse_pkg::ST_IDLE;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end
            end
            cse_pkg::ST_TWIST: begin
                o_ctl.twist = 1'b1;
                n_state     = cse_pkg::ST_IDLE;
            end
            default: begin
                n_state = cse_pkg::ST_IDLE;
            end
        endcase
        n_out_valid = o_take ? 1'b1 : (r_out_valid && i_out_stall);
    end

    assign o_in_stall  = (r_state != cse_pkg::ST_IDLE);
    assign o_result    = r_dec ? i_right0 : i_left0;
    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_run_starts_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_run && i_sym_ok) |=> (r_state == cse_pkg::ST_SEARCH))
        else $error("in-range run word did not start a search");

    a_twist_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cse_pkg::ST_TWIST) |=> (r_state == cse_pkg::ST_IDLE))
        else $error("twist did not return to idle");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= CNT_LAST))
        else $error("search count past last slot");

    a_search_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cse_pkg::ST_SEARCH && !w_match && r_count != CNT_LAST)
        |=> (r_state == cse_pkg::ST_SEARCH && r_count == $past(r_count) + 1'b1))
        else $error("search did not advance by one slot");

    a_take_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |=> r_out_valid)
        else $error("taken result not presented");
`endif

endmodule

// ===== sv/chaocipher_symbol_engine.sv =====
// top level of the chaocipher symbol engine: row of alphabet cells and sequencer
//
// channel  direction  handshake                  payload
// input    in         i_in_valid / o_in_stall    i_kind, i_position, i_symbol, i_restart
// output   out        o_out_valid / i_out_stall  o_out_symbol
//
// a load word leaves the sequencer idle; an encrypt or decrypt word holds o_in_stall
// through its search and twist, or through a full search when the symbol is absent
// a cipher word whose symbol is outside the alphabet leaves the sequencer idle, like a load
// the search rotates the whole cell row one slot per cycle until the zenith matches,
// then the twist state applies the nadir moves (right alphabet with its extra shift)
// reset clears the sequencer and the output valid flag; alphabets are undefined until loaded
// a stalled output holds the search at its match until the result register frees
module chaocipher_symbol_engine #(
    parameter int SYMBOLS = 27,
    parameter int NADIR   = 13
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [cse_pkg::KIND_W-1:0] i_kind,
    input  logic [cse_pkg::SYM_W-1:0]  i_position,
    input  logic [cse_pkg::SYM_W-1:0]  i_symbol,
    input  logic                      i_restart,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [cse_pkg::SYM_W-1:0]  o_out_symbol
);

    // nadir slot, limited to the last slot of the alphabet
    localparam int NADIR_IDX = (NADIR < SYMBOLS - 1) ? NADIR : SYMBOLS - 1;
    localparam logic [cse_pkg::SYM_W:0] SYM_LIMIT = (cse_pkg::SYM_W + 1)'(SYMBOLS);

    cse_pkg::t_cell_ctl        w_ctl;
    logic                      w_take;
    logic                      w_pos_ok;
    logic                      w_sym_ok;
    logic [cse_pkg::SYM_W-1:0] w_result;
    logic [cse_pkg::SYM_W-1:0] r_out_symbol;

    // working alphabets as seen at each cell, slot 0 is the zenith
    logic [cse_pkg::SYM_W-1:0] w_left  [SYMBOLS];
    logic [cse_pkg::SYM_W-1:0] w_right [SYMBOLS];

    assign w_pos_ok = {1'b0, i_position} < SYM_LIMIT;
    assign w_sym_ok = {1'b0, i_symbol} < SYM_LIMIT;

    cse_ctrl #(
        .SYMBOLS (SYMBOLS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_kind      (i_kind),
        .i_symbol    (i_symbol),
        .i_restart   (i_restart),
        .i_pos_ok    (w_pos_ok),
        .i_sym_ok    (w_sym_ok),
        .i_left0     (w_left[0]),
        .i_right0    (w_right[0]),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_ctl       (w_ctl),
        .o_take      (w_take),
        .o_result    (w_result),
        .o_out_valid (o_out_valid)
    );

    genvar gi;
    generate
        for (gi = 0; gi < SYMBOLS; gi++) begin : g_cell
            localparam int NX  = (gi + 1) % SYMBOLS;
            localparam int NX2 = (gi + 2) % SYMBOLS;

            logic [cse_pkg::SYM_W-1:0] w_left_tw;
            logic [cse_pkg::SYM_W-1:0] w_right_tw;
            logic                      w_hit;

            assign w_hit = (i_position == cse_pkg::SYM_W'(gi));

            // left: zenith already at slot 0, slot 1 moves to the nadir
            if (gi >= 1 && gi < NADIR_IDX) begin : g_lshift
                assign w_left_tw = w_left[NX];
            end else if (gi == NADIR_IDX) begin : g_lnadir
                assign w_left_tw = w_left[1];
            end else begin : g_lhold
                assign w_left_tw = w_left[gi];
            end

            // right: one extra slot of rotation, then slot 2 moves to the nadir
            if (NADIR_IDX > 2 && gi >= 2 && gi < NADIR_IDX) begin : g_rshift
                assign w_right_tw = w_right[NX2];
            end else if (NADIR_IDX > 2 && gi == NADIR_IDX) begin : g_rnadir
                assign w_right_tw = w_right[3];
            end else begin : g_rstep
                assign w_right_tw = w_right[NX];
            end

            cse_cell u_cell (
                .i_clk         (i_clk),
                .i_ctl         (w_ctl),
                .i_load_left   (w_ctl.load_left && w_hit),
                .i_load_right  (w_ctl.load_right && w_hit),
                .i_key_data    (i_symbol),
                .i_left_next   (w_left[NX]),
                .i_right_next  (w_right[NX]),
                .i_left_twist  (w_left_tw),
                .i_right_twist (w_right_tw),
                .o_left        (w_left[gi]),
                .o_right       (w_right[gi])
            );
        end
    endgenerate

    // result register, loaded when the zenith match is taken
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_symbol <= w_result;
        end
    end

    assign o_out_symbol = r_out_symbol;

endmodule
